/* rtl/imu_srf_pkg.sv */
package imu_srf_pkg;

    // Record layout
    localparam logic [7:0] REC_TYPE_IMU    = 8'h01;
    localparam int         AXES_PER_SENSOR = 6;
    localparam int         SLICE_SENSORS   = 6;   // sensors whose slice starts below bit 32
    localparam logic [3:0] FIXED_BYTES     = 4'd12; // type, length, index, timestamp
    localparam logic [3:0] LEN_LO_POS      = 4'd1;
    localparam logic [3:0] LEN_HI_POS      = 4'd2;
    localparam logic [3:0] INDEX_POS       = 4'd3;
    localparam logic [3:0] TS_FIRST_POS    = 4'd4;
    localparam logic [3:0] TS_LAST_POS     = 4'd11;
    localparam logic [4:0] BASE_PAYLOAD    = 5'd9;

    // Register map (word index taken from paddr[2])
    localparam logic REG_CHANNEL_MASK = 1'b0;

    // Input word as packed on s_axis_tdata
    typedef struct packed {
        logic [5:0][15:0] axis;
        logic [7:0][7:0]  ts;
        logic [7:0]       sensor_index;
    } sample_t;

    // Classified sample handed from front to back
    typedef struct packed {
        sample_t    sample;
        logic [5:0] axis_bits;
        logic [4:0] body_len;
    } rec_desc_t;

endpackage

/* rtl/imu_sample_record_framer.sv */
// IMU sample record framer. Each sample word on s_axis becomes one record on
// m_axis, one byte per word, tlast on the final byte: type 0x01, 16-bit
// little-endian payload length, sensor index, 8 timestamp bytes, then each
// axis enabled by the sensor's slice of channel_mask as 2 bytes.
// Records are 12 to 24 bytes, serialized by the byte serializer in the back
// end. Samples are classified on entry and wait in a FIFO_DEPTH-deep queue,
// so a new sample is taken while the previous record still streams, and the
// next record follows its predecessor with no gap. A sample accepted into an
// idle block passes through the queue, the back end's descriptor register and
// the output register before its first byte appears. Write channel_mask only
// while no record is pending.
module imu_sample_record_framer
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Sample input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [167:0] s_axis_tdata,  // sensor_index, sample_time, axis_0 .. axis_5
    // Record output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,  // record_byte
    output logic         m_axis_tlast   // last_byte
);
    import imu_srf_pkg::*;

    logic [31:0] channel_mask_reg;
    rec_desc_t   front_desc;
    rec_desc_t   queue_desc;
    logic        queue_valid;
    logic        queue_pop;
    logic        cfg_write;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL_MASK);
    assign prdata    = (paddr[2] == REG_CHANNEL_MASK) ? channel_mask_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mask_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            channel_mask_reg <= pwdata;
        end
    end

    // Front end: classify the sample
    imu_srf_front u_front
    (
        .sample       (sample_t'(s_axis_tdata)),
        .channel_mask (channel_mask_reg),
        .desc         (front_desc)
    );

    // Queue between front and back
    imu_srf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_desc   (front_desc),
        .out_valid (queue_valid),
        .out_pop   (queue_pop),
        .out_desc  (queue_desc)
    );

    // Back end: serialize the record
    imu_srf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_pop    (queue_pop),
        .in_desc   (queue_desc),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

/* rtl/imu_srf_front.sv */
module imu_srf_front
(
    input  imu_srf_pkg::sample_t   sample,
    input  logic [31:0]            channel_mask,
    output imu_srf_pkg::rec_desc_t desc
);
    import imu_srf_pkg::*;

    logic [5:0] slice;
    logic [2:0] axis_cnt;

    // Pick the six-bit slice of the mask for this sensor
    always_comb
    begin
        slice = 6'd0;
        if (sample.sensor_index[7:3] == 5'd0)
        begin
            case (sample.sensor_index[2:0])
                3'd0:    slice = channel_mask[5:0];
                3'd1:    slice = channel_mask[11:6];
                3'd2:    slice = channel_mask[17:12];
                3'd3:    slice = channel_mask[23:18];
                3'd4:    slice = channel_mask[29:24];
                3'd5:    slice = {4'd0, channel_mask[31:30]};
                default: slice = 6'd0;
            endcase
        end
    end

    // Count enabled axes for the payload length
    always_comb
    begin
        axis_cnt = 3'd0;
        for (int i = 0; i < AXES_PER_SENSOR; i++)
        begin
            axis_cnt = axis_cnt + {2'd0, slice[i]};
        end
    end

    always_comb
    begin
        desc.sample    = sample;
        desc.axis_bits = slice;
        desc.body_len  = BASE_PAYLOAD + {1'b0, axis_cnt, 1'b0};
    end

endmodule

/* rtl/imu_srf_fifo.sv */
module imu_srf_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  imu_srf_pkg::rec_desc_t in_desc,
    output logic                   out_valid,
    input  logic                   out_pop,
    output imu_srf_pkg::rec_desc_t out_desc
);
    import imu_srf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_desc_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_desc  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_desc;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count over depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("fifo pointers disagree with count");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fifo count missed a push");
`endif

endmodule

/* rtl/imu_srf_back.sv */
module imu_srf_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_pop,
    input  imu_srf_pkg::rec_desc_t in_desc,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);
    import imu_srf_pkg::*;

    rec_desc_t  desc_reg, desc_next;
    logic       act_reg, act_next;
    logic [3:0] pos_reg, pos_next;
    logic [5:0] rem_reg, rem_next;
    logic       half_reg, half_next;
    logic       oval_reg, oval_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       olast_reg, olast_next;

    logic       adv;
    logic       emit;
    logic       axis_phase;
    logic [2:0] sel_k;
    logic [5:0] rem_clr;
    logic [2:0] ts_idx;
    logic [15:0] cur_axis;
    logic [7:0] cur_byte;
    logic       is_last;

    assign adv        = !oval_reg || out_ready;
    assign emit       = act_reg && adv;
    assign axis_phase = (pos_reg == FIXED_BYTES);
    assign in_pop     = in_valid && (!act_reg || (emit && is_last));
    assign ts_idx     = 3'(pos_reg - TS_FIRST_POS);

    // Lowest remaining enabled axis
    always_comb
    begin
        sel_k = 3'd0;
        for (int i = AXES_PER_SENSOR - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                sel_k = 3'(i);
            end
        end
    end

    assign rem_clr  = rem_reg & ~(6'd1 << sel_k);
    assign cur_axis = desc_reg.sample.axis[sel_k];

    // Byte select and end-of-record detect
    always_comb
    begin
        if (axis_phase)
        begin
            cur_byte = half_reg ? cur_axis[15:8] : cur_axis[7:0];
            is_last  = half_reg && (rem_clr == 6'd0);
        end
        else
        begin
            case (pos_reg)
                4'd0:       cur_byte = REC_TYPE_IMU;
                LEN_LO_POS: cur_byte = {3'd0, desc_reg.body_len};
                LEN_HI_POS: cur_byte = 8'h00;
                INDEX_POS:  cur_byte = desc_reg.sample.sensor_index;
                default:    cur_byte = desc_reg.sample.ts[ts_idx];
            endcase
            is_last = (pos_reg == TS_LAST_POS) && (rem_reg == 6'd0);
        end
    end

    // Serializer sequencing
    always_comb
    begin
        desc_next  = desc_reg;
        act_next   = act_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        half_next  = half_reg;
        oval_next  = oval_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;

        if (emit)
        begin
            if (axis_phase)
            begin
                half_next = !half_reg;
                if (half_reg)
                begin
                    rem_next = rem_clr;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        if (in_pop)
        begin
            desc_next = in_desc;
            act_next  = 1'b1;
            pos_next  = 4'd0;
            rem_next  = in_desc.axis_bits;
            half_next = 1'b0;
        end
        else if (emit && is_last)
        begin
            act_next = 1'b0;
        end

        // Output register
        if (adv)
        begin
            oval_next  = emit;
            obyte_next = cur_byte;
            olast_next = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            pos_reg  <= 4'd0;
            rem_reg  <= 6'd0;
            half_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            pos_reg  <= pos_next;
            rem_reg  <= rem_next;
            half_reg <= half_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg  <= desc_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

`ifndef SYNTHESIS
    a_axis_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && axis_phase) |-> (rem_reg != 6'd0))
        else $error("axis phase with no axis left");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= FIXED_BYTES)
        else $error("byte position out of range");

    a_half_in_axis: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> axis_phase)
        else $error("high axis byte outside axis phase");
`endif

endmodule

/* verif/tb_imu_sample_record_framer.sv */
module tb_imu_sample_record_framer;

    import imu_srf_pkg::*;

    localparam int         HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int         WATCHDOG_CYCLES = 1000;  // cycles with no word moved
    localparam int         SETTLE_CYCLES   = 4;     // margin after the last expected byte
    localparam int         TAIL_CYCLES     = 40;
    localparam int         PHASES          = 7;
    localparam int         ITEMS_PER_PHASE = 30;
    localparam logic [2:0] MASK_ADDR       = {REG_CHANNEL_MASK, 2'b00};

    typedef struct {
        logic [7:0] data;
        logic       last;
    } rec_byte_t;

    // Directed row: mask to run under, the sample, and a typed payload length
    // (zero means the predictor supplies it)
    typedef struct {
        logic [31:0]      mask;
        logic [7:0]       idx;
        logic [63:0]      ts;
        logic [5:0][15:0] axes;
        int               plen;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;  // sensor_index, sample_time, axis_0 .. axis_5
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;       // record_byte
    logic         m_axis_tlast;       // last_byte

    logic [31:0]  mask_cfg = '0;
    int           len_typed = 0;
    rec_byte_t    record_due[$];
    int           mismatches = 0;
    int           bytes_seen = 0;
    int           stalled = 0;
    int           burst_left = 0;
    bit           hold_req = 1'b0;
    rx_mode_t     rx_mode = RX_OPEN;
    int           rx_left = 0;

    dir_row_t     dir_tab[22];

    imu_sample_record_framer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Build the record a sample should produce and queue its bytes
    function automatic void frame_sample(input sample_t s, input logic [31:0] mask,
                                         input int plen_typed);
        logic [5:0]  axis_en;
        logic [15:0] plen;
        rec_byte_t   rec[$];
        rec_byte_t   b;
        axis_en = '0;
        if (s.sensor_index < SLICE_SENSORS)
        begin
            axis_en = 6'(mask >> (s.sensor_index * AXES_PER_SENSOR));
        end
        plen = 16'(BASE_PAYLOAD);
        for (int k = 0; k < AXES_PER_SENSOR; k++)
        begin
            if (axis_en[k])
            begin
                plen += 16'd2;
            end
        end
        if (plen_typed != 0)
        begin
            plen = plen_typed[15:0];
        end
        b.last = 1'b0;
        b.data = REC_TYPE_IMU;    rec.push_back(b);
        b.data = plen[7:0];       rec.push_back(b);
        b.data = plen[15:8];      rec.push_back(b);
        b.data = s.sensor_index;  rec.push_back(b);
        for (int k = 0; k < 8; k++)
        begin
            b.data = s.ts[k];
            rec.push_back(b);
        end
        for (int k = 0; k < AXES_PER_SENSOR; k++)
        begin
            if (axis_en[k])
            begin
                b.data = s.axis[k][7:0];   rec.push_back(b);
                b.data = s.axis[k][15:8];  rec.push_back(b);
            end
        end
        rec[rec.size() - 1].last = 1'b1;
        foreach (rec[i])
        begin
            record_due.push_back(rec[i]);
        end
    endfunction

    // Sample monitor, record checker and watchdog
    always @(posedge clk)
    begin
        rec_byte_t want;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                frame_sample(s_axis_tdata, mask_cfg, len_typed);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (record_due.size() == 0)
                begin
                    $display("%0t: byte %0d not expected, got %02h last %0b",
                             $time, bytes_seen, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = record_due.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $display("%0t: byte %0d record_byte expected %02h got %02h",
                                 $time, bytes_seen, want.data, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $display("%0t: byte %0d last_byte expected %0b got %0b",
                                 $time, bytes_seen, want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
                bytes_seen++;
            end
            stalled = moved ? 0 : stalled + 1;
            if (stalled >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no word moved for %0d cycles, %0d bytes outstanding",
                         $time, stalled, record_due.size());
                $display("[imu_sample_record_framer] ERROR");
                $finish;
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_req = 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:   m_axis_tready <= (rx_left % 4 == 0);
            endcase
        end
    end

    // One APB transfer: setup cycle, then access cycle
    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MASK_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering and wait until every queued byte has come out
    task automatic drain_records();
        s_axis_tvalid <= 1'b0;
        while (record_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_channel_mask(input logic [31:0] m);
        logic [31:0] rd;
        drain_records();
        apb_xfer(1'b1, m, rd);
        mask_cfg = m;
        apb_xfer(1'b0, '0, rd);
        if (rd !== m)
        begin
            $display("%0t: channel_mask read expected %08h got %08h", $time, m, rd);
            mismatches++;
        end
    endtask

    // Offer one sample and hold it until taken; returns at a falling edge
    task automatic offer_sample(input sample_t s, input int plen_typed);
        s_axis_tdata  <= s;
        s_axis_tvalid <= 1'b1;
        len_typed     <= plen_typed;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Bursts of back-to-back words separated by random gaps
    task automatic sender_gap();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        case ($urandom_range(0, 9))
            7, 8:    s.sensor_index = 8'($urandom_range(6, 7));
            9:       s.sensor_index = 8'($urandom_range(0, 255));
            default: s.sensor_index = 8'($urandom_range(0, 5));
        endcase
        case ($urandom_range(0, 7))
            0:       s.ts = 64'h8000_0000_0000_0000;
            1:       s.ts = 64'h7FFF_FFFF_FFFF_FFFF;
            2:       s.ts = '1;
            default: s.ts = {$urandom, $urandom};
        endcase
        for (int k = 0; k < AXES_PER_SENSOR; k++)
        begin
            s.axis[k] = 16'($urandom);
        end
        return s;
    endfunction

    initial
    begin
        logic [31:0] rd;
        logic [31:0] phase_mask;
        sample_t     s;

        // Directed rows: reset mask, field extremes, axis 0 and axis 5 alone,
        // partial slice for sensor 5, slices past the mask for sensor 6 up
        dir_tab = '{
            '{32'h0000_0000, 8'd0,   64'h0,                    96'h0,              9},
            '{32'h0000_0000, 8'd255, 64'h7FFF_FFFF_FFFF_FFFF,  {6{16'h7FFF}},      9},
            '{32'hFFFF_FFFF, 8'd0,   64'h8000_0000_0000_0000,  {6{16'h8000}},     21},
            '{32'hFFFF_FFFF, 8'd1,   64'hFFFF_FFFF_FFFF_FFFF,  {6{16'hFFFF}},     21},
            '{32'hFFFF_FFFF, 8'd4,   64'h0123_4567_89AB_CDEF,
              96'h6666_5555_4444_3333_2222_1111,                                 21},
            '{32'hFFFF_FFFF, 8'd5,   64'hFEDC_BA98_7654_3210,
              96'hA5A5_5A5A_0FF0_F00F_8001_7FFE,                                 13},
            '{32'hFFFF_FFFF, 8'd6,   64'h0000_0000_0000_0001,  {6{16'h1234}},      9},
            '{32'hFFFF_FFFF, 8'd255, 64'hFFFF_FFFF_FFFF_FFFE,  {6{16'hABCD}},      9},
            '{32'hFFFF_FFFF, 8'd42,  64'h5555_AAAA_5555_AAAA,  {6{16'h0001}},      9},
            '{32'h0000_003F, 8'd0,   64'hAAAA_5555_AAAA_5555,
              96'h0102_0304_0506_0708_090A_0B0C,                                 21},
            '{32'h0000_003F, 8'd1,   64'h1,                    {6{16'hFFFF}},      9},
            '{32'h0000_0001, 8'd0,   64'h2,                    96'hFFFF_0000_FFFF_0000_FFFF_8001, 11},
            '{32'h0000_0020, 8'd0,   64'h3,                    96'h7FFF_0000_0000_0000_0000_0000, 11},
            '{32'hC000_0000, 8'd5,   64'h4,                    96'h1111_2222_3333_4444_8000_7FFF, 13},
            '{32'hC000_0000, 8'd4,   64'h5,                    {6{16'h5A5A}},      9},
            '{32'h4000_0000, 8'd5,   64'h6,                    96'h0_0000_0000_0000_BEEF_C0DE,   11},
            '{32'hA5C3_9617, 8'd0,   64'h1122_3344_5566_7788,
              96'h0F0F_F0F0_3C3C_C3C3_A5A5_5A5A,                                  0},
            '{32'hA5C3_9617, 8'd1,   64'h8877_6655_4433_2211,
              96'h1357_9BDF_2468_ACE0_FEDC_0123,                                  0},
            '{32'hA5C3_9617, 8'd2,   64'hDEAD_BEEF_0BAD_F00D,  {6{16'hC3A5}},      0},
            '{32'hA5C3_9617, 8'd3,   64'h0F1E_2D3C_4B5A_6978,  {6{16'h9669}},      0},
            '{32'hA5C3_9617, 8'd4,   64'h7766_5544_3322_1100,  {6{16'h0FF0}},      0},
            '{32'hA5C3_9617, 8'd5,   64'hCAFE_F00D_1234_5678,  {6{16'h3CC3}},      0}
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // channel_mask comes out of reset as zero
        apb_xfer(1'b0, '0, rd);
        if (rd !== 32'h0)
        begin
            $display("%0t: channel_mask reset expected %08h got %08h", $time, 32'h0, rd);
            mismatches++;
        end

        // Directed part
        foreach (dir_tab[r])
        begin
            if (dir_tab[r].mask != mask_cfg)
            begin
                set_channel_mask(dir_tab[r].mask);
            end
            s.sensor_index = dir_tab[r].idx;
            s.ts           = dir_tab[r].ts;
            s.axis         = dir_tab[r].axes;
            offer_sample(s, dir_tab[r].plen);
            sender_gap();
        end

        // Random part, one mask setting per phase
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_mask = 32'hFFFF_FFFF;
                2:       phase_mask = 32'h0000_0000;
                4:       phase_mask = 32'hC000_0FC0;
                default: phase_mask = $urandom;
            endcase
            set_channel_mask(phase_mask);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Receiver holds off while the sender keeps pushing
                if (p == 1 && i == 10)
                begin
                    hold_req = 1'b1;
                    burst_left = 10;
                end
                // Sender waits for every outstanding record
                if ((p == 3 && i == 15) || $urandom_range(0, 24) == 0)
                begin
                    drain_records();
                end
                offer_sample(random_sample(), 0);
                sender_gap();
            end
        end

        drain_records();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && record_due.size() == 0)
        begin
            $display("[imu_sample_record_framer] OK");
        end
        else
        begin
            $display("[imu_sample_record_framer] ERROR");
        end
        $finish;
    end

endmodule
